FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/rcsp_pkg.sv
// ---------------------------------------------------------------------------
// rcsp_pkg
// Types and constants shared by the request stream parser.
// ---------------------------------------------------------------------------
package rcsp_pkg;

	localparam int ARG_W      = 11;
	localparam int LEN_CFG_W  = 30;
	localparam int CFG_DATA_W = 30;
	localparam int CFG_IDX_W  = 1;

	localparam logic [ARG_W-1:0]     MAX_ARG_RESET = 11'd1024;
	localparam logic [LEN_CFG_W-1:0] MAX_LEN_RESET = 30'd536870912;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_ARG_COUNT = 1'b0,
		REG_MAX_BULK_LEN  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		TK_OTHER,
		TK_DIGIT,
		TK_MINUS,
		TK_STAR,
		TK_DOLLAR,
		TK_LF,
		TK_CR
	} tok_class_t;

	typedef struct packed {
		logic [7:0] data;
		tok_class_t cls;
	} token_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_ARG_END = 2'd1,
		KIND_CMD_END = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_COUNT = 2'd0,
		ERR_LEN   = 2'd1,
		ERR_LIMIT = 2'd2
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [9:0]  argument_index;
		err_t        error_code;
	} result_t;

endpackage

FILE: rtl/core/rcsp_fifo.sv
// ---------------------------------------------------------------------------
// rcsp_fifo
// Small register-based queue; head entry is presented while not empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcsp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`ASSERT_NEXT(a_push_only_grows, clk, arst_n, do_push && !do_pop, !empty)

endmodule

FILE: rtl/core/rcsp_front.sv
// ---------------------------------------------------------------------------
// rcsp_front
// Byte intake: classifies each request byte and queues it as a token.
// ---------------------------------------------------------------------------
module rcsp_front
	import rcsp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	output logic       full,
	input  logic       tok_pop,
	output token_t     tok,
	output logic       tok_valid
);

	token_t in_tok;
	logic   tok_empty;

	always_comb begin
		in_tok.data = data_byte;
		if (data_byte inside {[CH_ZERO:CH_NINE]}) begin
			in_tok.cls = TK_DIGIT;
		end else begin
			case (data_byte)
				CH_MINUS:  in_tok.cls = TK_MINUS;
				CH_STAR:   in_tok.cls = TK_STAR;
				CH_DOLLAR: in_tok.cls = TK_DOLLAR;
				CH_LF:     in_tok.cls = TK_LF;
				CH_CR:     in_tok.cls = TK_CR;
				default:   in_tok.cls = TK_OTHER;
			endcase
		end
	end

	rcsp_fifo #(
		.WIDTH ($bits(token_t)),
		.DEPTH (DEPTH)
	) u_tok_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_tok),
		.full  (full),
		.pop   (tok_pop),
		.rdata (tok),
		.empty (tok_empty)
	);

	assign tok_valid = !tok_empty;

endmodule

FILE: rtl/core/rcsp_back.sv
// ---------------------------------------------------------------------------
// rcsp_back
// Parse engine: count, length, payload phases; one token per unstalled cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rcsp_back
	import rcsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  tok_valid,
	input  token_t                tok,
	output logic                  tok_pop,
	input  logic                  res_full,
	output logic                  res_push,
	output result_t               res
);

	localparam int LW    = LENGTH_WIDTH;
	localparam int CMP_W = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COUNT,
		PH_LEN,
		PH_DATA
	} phase_t;

	logic [ARG_W-1:0]     max_arg_q;
	logic [LEN_CFG_W-1:0] max_len_q;

	phase_t           phase_q, phase_d;
	logic [LW-1:0]    value_q, value_d;
	logic             neg_q, neg_d, digit_q, digit_d, stop_q, stop_d;
	logic [ARG_W-1:0] exp_q, exp_d, args_q, args_d;
	logic [LW-1:0]    bulk_q, bulk_d, pcount_q, pcount_d;

	// number accumulation
	logic [LW+3:0] prod;
	logic [LW-1:0] sat_value, fed_value, len_sel;
	logic          fed_neg, fed_digit, fed_stop;

	assign prod = ({4'b0, value_q} << 3) + ({4'b0, value_q} << 1)
		+ (LW + 4)'(tok.data[3:0]);
	assign sat_value = (|prod[LW+3:LW]) ? '1 : prod[LW-1:0];
	assign len_sel   = neg_q ? '0 : value_q;

	always_comb begin
		fed_value = value_q;
		fed_neg   = neg_q;
		fed_digit = digit_q;
		fed_stop  = stop_q;
		if (!stop_q) begin
			case (tok.cls)
				TK_DIGIT: begin
					fed_value = sat_value;
					fed_digit = 1'b1;
				end
				TK_MINUS: begin
					if (!neg_q && !digit_q) begin
						fed_neg = 1'b1;
					end else begin
						fed_stop = 1'b1;
					end
				end
				default: fed_stop = 1'b1;
			endcase
		end
	end

	always_comb begin
		phase_d  = phase_q;
		value_d  = value_q;
		neg_d    = neg_q;
		digit_d  = digit_q;
		stop_d   = stop_q;
		exp_d    = exp_q;
		args_d   = args_q;
		bulk_d   = bulk_q;
		pcount_d = pcount_q;
		res_push = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.payload_byte   = '0;
		res.argument_index = args_q[9:0];
		res.error_code     = ERR_COUNT;
		tok_pop  = tok_valid && !res_full;

		if (tok_pop) begin
			case (phase_q)
				PH_IDLE: begin
					if (tok.cls == TK_STAR) begin
						phase_d = PH_COUNT;
						value_d = '0;
						neg_d   = 1'b0;
						digit_d = 1'b0;
						stop_d  = 1'b0;
					end
				end
				PH_COUNT: begin
					if (tok.cls == TK_LF) begin
						if (!digit_q || neg_q || value_q == '0) begin
							res_push       = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_COUNT;
						end else if (CMP_W'(value_q) > CMP_W'(max_arg_q)) begin
							res_push       = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_LIMIT;
						end else begin
							exp_d   = ARG_W'(value_q);
							args_d  = '0;
							phase_d = PH_LEN;
							value_d = '0;
							neg_d   = 1'b0;
							digit_d = 1'b0;
							stop_d  = 1'b0;
						end
					end else if (tok.cls != TK_CR) begin
						value_d = fed_value;
						neg_d   = fed_neg;
						digit_d = fed_digit;
						stop_d  = fed_stop;
					end
				end
				PH_LEN: begin
					if (tok.cls == TK_DOLLAR) begin
						value_d = '0;
						neg_d   = 1'b0;
						digit_d = 1'b0;
						stop_d  = 1'b0;
					end else if (tok.cls == TK_LF) begin
						if (neg_q || digit_q || stop_q) begin
							if (!digit_q) begin
								res_push       = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_LEN;
							end else if (CMP_W'(len_sel) > CMP_W'(max_len_q)) begin
								res_push       = 1'b1;
								res.kind       = KIND_ERROR;
								res.error_code = ERR_LIMIT;
							end else begin
								bulk_d   = len_sel;
								pcount_d = '0;
								phase_d  = PH_DATA;
								value_d  = '0;
								neg_d    = 1'b0;
								digit_d  = 1'b0;
								stop_d   = 1'b0;
							end
						end
					end else if (tok.cls != TK_CR) begin
						value_d = fed_value;
						neg_d   = fed_neg;
						digit_d = fed_digit;
						stop_d  = fed_stop;
					end
				end
				PH_DATA: begin
					if (pcount_q < bulk_q) begin
						pcount_d         = pcount_q + 1'b1;
						res_push         = 1'b1;
						res.kind         = KIND_PAYLOAD;
						res.payload_byte = tok.data;
					end else if (tok.cls == TK_LF) begin
						res_push = 1'b1;
						if (ARG_W'(args_q + 1'b1) == exp_q) begin
							res.kind = KIND_CMD_END;
							phase_d  = PH_IDLE;
							exp_d    = '0;
							args_d   = '0;
						end else begin
							res.kind = KIND_ARG_END;
							args_d   = args_q + 1'b1;
							phase_d  = PH_LEN;
						end
						bulk_d   = '0;
						pcount_d = '0;
						value_d  = '0;
						neg_d    = 1'b0;
						digit_d  = 1'b0;
						stop_d   = 1'b0;
					end
				end
				default: phase_d = PH_IDLE;
			endcase

			// errors drop all parse state
			if (res_push && res.kind == KIND_ERROR) begin
				phase_d  = PH_IDLE;
				value_d  = '0;
				neg_d    = 1'b0;
				digit_d  = 1'b0;
				stop_d   = 1'b0;
				exp_d    = '0;
				args_d   = '0;
				bulk_d   = '0;
				pcount_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_arg_q <= MAX_ARG_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAX_ARG_COUNT: max_arg_q <= cfg_data[ARG_W-1:0];
				REG_MAX_BULK_LEN:  max_len_q <= cfg_data[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			value_q  <= '0;
			neg_q    <= 1'b0;
			digit_q  <= 1'b0;
			stop_q   <= 1'b0;
			exp_q    <= '0;
			args_q   <= '0;
			bulk_q   <= '0;
			pcount_q <= '0;
		end else begin
			phase_q  <= phase_d;
			value_q  <= value_d;
			neg_q    <= neg_d;
			digit_q  <= digit_d;
			stop_q   <= stop_d;
			exp_q    <= exp_d;
			args_q   <= args_d;
			bulk_q   <= bulk_d;
			pcount_q <= pcount_d;
		end
	end

	`ASSERT_IMPLIES(a_payload_bound, clk, arst_n, 1'b1, pcount_q <= bulk_q)
	`ASSERT_IMPLIES(a_idle_clean, clk, arst_n, phase_q == PH_IDLE,
		args_q == '0 && pcount_q == '0 && bulk_q == '0)
	`ASSERT_NEXT(a_error_to_idle, clk, arst_n, res_push && res.kind == KIND_ERROR,
		phase_q == PH_IDLE)

endmodule

FILE: rtl/core/resp_command_stream_parser.sv
// ---------------------------------------------------------------------------
// resp_command_stream_parser
// Streaming parser for request arrays of bulk strings.
// ---------------------------------------------------------------------------
// Takes one request byte per cycle while not full and gives at most one result
// per byte, sustained at one byte every clock while results are popped. A byte
// pushed into an empty block is registered in the token queue behind the
// classifier, and its result in the result queue behind the parse engine,
// before it reaches the result ports and can be popped. The parse engine's
// combinational decimal accumulate and limit compare set the clock. The user
// must write limits only while the block is idle; the block does not enforce
// this.
module resp_command_stream_parser
	import rcsp_pkg::*;
#(
	parameter int LENGTH_WIDTH = 30,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  logic [7:0]            data_byte,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            kind,
	output logic [7:0]            payload_byte,
	output logic [9:0]            argument_index,
	output logic [1:0]            error_code
);

	token_t  tok;
	logic    tok_valid, tok_pop;
	logic    res_push, res_full;
	result_t res_in, res_out;

	rcsp_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.data_byte(data_byte),
		.full     (full),
		.tok_pop  (tok_pop),
		.tok      (tok),
		.tok_valid(tok_valid)
	);

	rcsp_back #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.tok_valid(tok_valid),
		.tok      (tok),
		.tok_pop  (tok_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	rcsp_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign kind           = res_out.kind;
	assign payload_byte   = res_out.payload_byte;
	assign argument_index = res_out.argument_index;
	assign error_code     = res_out.error_code;

endmodule
